// ----- src/dmm_pkg.sv -----
`timescale 1ns / 1ps

package dmm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ROWS_OF_A  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_COLS_OF_B  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 35;
    localparam int IDX_W  = 3;
    localparam int DIM_W  = 4;

endpackage

// ----- src/dmm_ram.sv -----
`timescale 1ns / 1ps

module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/dense_matrix_multiply_unit.sv -----
`timescale 1ns / 1ps
// Dense matrix multiply C = A x B on Q1.15 elements, exact Q5.30 sums.
// Input channel (in_valid/in_ready): op 0 writes op's row/col entry of A, op 1
// of B, op 2 starts a product run, op 3 is dropped.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..2 selects
// rows_of_a, inner_size, cols_of_b; write only while no run is in progress.
// A dimension of 0 acts as 1, above MAX_DIM acts as MAX_DIM.
// Output channel (out_valid/out_ready): one beat per element of C, row-major,
// last set on the final element. The output register lets the next element
// proceed while a beat waits.
// Datapath: one shared 16x16 multiplier and 35-bit accumulator. For each
// element the sequencer issues one read and MAC per inner index, then drains
// the pipeline and pushes the result; a run also waits out any stall on
// out_ready. in_ready is low for the whole run.
// A stalled receiver holds the sequencer in the push step; nothing is lost.
// Reset clears the dimension registers to 8 and the sequencer to idle; the
// A/B stores are not cleared and must be written before they are used.
module dense_matrix_multiply_unit
    import dmm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               op,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [ELEM_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ACC_W-1:0]  product,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic                     last,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [DIM_W-1:0]         cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [IDX_W-1:0] r_reg, c_reg, k_reg;
    logic [IDX_W-1:0] r_next, c_next, k_next;

    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic out_valid_reg, last_reg;
    logic signed [ACC_W-1:0] product_reg;
    logic [IDX_W-1:0] out_row_reg, out_col_reg;

    logic [IDX_W-1:0] m_last, n_last, p_last;
    logic issue, push, out_free, elem_last, in_fire, wr_ok;
    logic we_a, we_b;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic signed [ELEM_W-1:0] rdata_a, rdata_b;

    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] e;
        begin
            e = d;
            if (d == '0)
            begin
                e = DIM_W'(1);
            end
            else if (d > DIM_W'(MAX_DIM))
            begin
                e = DIM_W'(MAX_DIM);
            end
            dim_last = IDX_W'(e - DIM_W'(1));
        end
    endfunction

    assign m_last = dim_last(rows_reg);
    assign n_last = dim_last(inner_reg);
    assign p_last = dim_last(cols_reg);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(8);
            inner_reg <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS_OF_A:  rows_reg  <= cfg_data;
                CFG_INNER_SIZE: inner_reg <= cfg_data;
                CFG_COLS_OF_B:  cols_reg  <= cfg_data;
                CFG_UNUSED:     ;
            endcase
        end
    end

    // store writes come straight from load beats
    assign in_fire = in_valid && in_ready;
    assign wr_ok   = ({1'b0, row} < DIM_W'(MAX_DIM)) && ({1'b0, col} < DIM_W'(MAX_DIM));
    assign we_a    = in_fire && wr_ok && (op_t'(op) == OP_LOAD_A);
    assign we_b    = in_fire && wr_ok && (op_t'(op) == OP_LOAD_B);
    assign waddr   = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
    assign raddr_a = ADDR_W'(r_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(k_reg);
    assign raddr_b = ADDR_W'(k_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(c_reg);

    dmm_ram #(
        .WIDTH  (ELEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    dmm_ram #(
        .WIDTH  (ELEM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign elem_last = (r_reg == m_last) && (c_reg == p_last);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op_t'(op) == OP_COMPUTE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == n_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && s2_last_reg)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = elem_last ? ST_IDLE : ST_RUN;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_RUN:   issue    = 1'b1;
            ST_DRAIN: ;
            ST_PUSH:  push     = out_free;
        endcase
    end

    // loop counters: k over the inner dimension, then c, then r
    always_comb
    begin
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        if (in_fire)
        begin
            r_next = '0;
            c_next = '0;
            k_next = '0;
        end
        else if (issue)
        begin
            k_next = (k_reg == n_last) ? '0 : k_reg + IDX_W'(1);
        end
        else if (push)
        begin
            if (c_reg == p_last)
            begin
                c_next = '0;
                r_next = r_reg + IDX_W'(1);
            end
            else
            begin
                c_next = c_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // MAC datapath: RAM read -> multiply -> accumulate
    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= (k_reg == n_last);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        prod_reg     <= rdata_a * rdata_b;
        if (s2_valid_reg)
        begin
            acc_reg <= (s2_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
        end
        if (push)
        begin
            product_reg <= acc_reg;
            out_row_reg <= r_reg;
            out_col_reg <= c_reg;
            last_reg    <= elem_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign last      = last_reg;

endmodule

// ----- src/dmm_checker.sv -----
`timescale 1ns / 1ps

module dmm_checker
    import dmm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [1:0]              op,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [ACC_W-1:0] product,
    input logic                    last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product) && $stable(last))
        else $error("result beat changed while stalled");

    // a compute beat starts a run that blocks the input
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_COMPUTE) |=> !in_ready)
        else $error("input ready right after compute beat");

    // load and dropped beats keep the block idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op != OP_COMPUTE) |=> in_ready)
        else $error("input not ready after load beat");

    // a pending non-final result means the run is still going
    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready during a run");

    // the run is over once its last beat shows up
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid && last) |-> in_ready)
        else $error("not idle when last beat appears");

endmodule

bind dense_matrix_multiply_unit dmm_checker u_dmm_checker (.*);
